>>> sv/irm_pkg.sv
// Package for the ICMP reply matcher: configuration and result structs,
// status and kind codes, register indexes and field widths.
// Used by every module of the block; depends on nothing.
package irm_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SEQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_TIME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TYPE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_EXC_TYPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_IP        = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;

    // Reset value of the time exceeded type register
    localparam logic [7:0] TIME_EXC_TYPE_RESET = 8'd11;

    // Result status codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_OTHER     = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    // Reply kind codes
    localparam logic KIND_ECHO     = 1'b0;
    localparam logic KIND_TIME_EXC = 1'b1;

    // Stream widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 72;

    typedef struct packed {
        logic [15:0] process_id;
        logic [15:0] expected_seq;
        logic [31:0] send_time;
        logic [7:0]  echo_reply_type;
        logic [7:0]  time_exceeded_type;
        logic [31:0] dest_ip;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reply_kind;
        logic [31:0] source_ip;
        logic        reached_dest;
        logic [31:0] round_trip_ms;
    } result_t;

endpackage

>>> sv/irm_cfg_regs.sv
// Configuration register file of the ICMP reply matcher.
// Depends on irm_pkg for register indexes, reset values and cfg_t.
module irm_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pipe_busy,
    output irm_pkg::cfg_t                   cfg
);
    import irm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    // Hold writes off while a word waits in the input register
    assign cfg_ready = !pipe_busy;
    assign wr        = cfg_valid && cfg_ready;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (cfg_index)
                REG_PROCESS_ID:    cfg_next.process_id         = cfg_data[15:0];
                REG_EXPECTED_SEQ:  cfg_next.expected_seq       = cfg_data[15:0];
                REG_SEND_TIME:     cfg_next.send_time          = cfg_data;
                REG_ECHO_TYPE:     cfg_next.echo_reply_type    = cfg_data[7:0];
                REG_TIME_EXC_TYPE: cfg_next.time_exceeded_type = cfg_data[7:0];
                REG_DEST_IP:       cfg_next.dest_ip            = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg                    <= '0;
            cfg_reg.time_exceeded_type <= TIME_EXC_TYPE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/irm_parser.sv
// Byte parser of the ICMP reply matcher: input register, per-packet field
// capture and classification on the last byte. Depends on irm_pkg.
module irm_parser #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_byte,
    input  logic                  s_last,
    input  logic [31:0]           s_now,
    input  logic                  cfg_valid,
    input  irm_pkg::cfg_t         cfg,
    input  logic                  out_free,
    output logic                  pipe_busy,
    output logic                  res_load,
    output irm_pkg::result_t      res
);
    import irm_pkg::*;

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = PW + 2;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_PACKET_BYTES);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [31:0] in_now_reg;

    // Packet state
    logic [PW-1:0] pos_reg, pos_next;
    logic [5:0]    hlen_reg, hlen_next;
    logic [7:0]    kind_reg, kind_next;
    logic [31:0]   src_reg, src_next;
    logic [7:0]    off_reg, off_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   seq_reg, seq_next;
    logic          done_reg, done_next;

    logic          adv, take, s_acc;
    logic [CW-1:0] p_w, h_w, off_w, len_w;
    logic          is_echo, is_te, icmp_hit;
    logic [1:0]    rel;

    // Advance the input word unless a result would find the output slot full
    assign adv       = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = (!in_valid_reg || adv) && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;
    assign pipe_busy = in_valid_reg;
    assign in_valid_next = s_acc || (in_valid_reg && !adv);
    assign take      = adv && (pos_reg < MAX_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_byte;
            in_last_reg <= s_last;
            in_now_reg  <= s_now;
        end
    end

    // Capture header fields from the current byte
    always_comb begin
        pos_next  = pos_reg;
        hlen_next = hlen_reg;
        kind_next = kind_reg;
        src_next  = src_reg;
        off_next  = off_reg;
        id_next   = id_reg;
        seq_next  = seq_reg;
        done_next = done_reg;
        icmp_hit  = 1'b0;
        rel       = 2'd0;

        if (pos_reg == '0) begin
            hlen_next = {in_byte_reg[3:0], 2'b00};
        end
        p_w   = CW'(pos_reg);
        h_w   = CW'(hlen_next);
        off_w = CW'(off_reg);

        if (take) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg >= PW'(12) && pos_reg <= PW'(15)) begin
                src_next[8*pos_reg[1:0] +: 8] = in_byte_reg;
            end
            if (p_w == h_w) begin
                kind_next = in_byte_reg;
            end
            if (p_w > h_w) begin
                if (kind_next == cfg.echo_reply_type) begin
                    if (p_w >= h_w + CW'(4) && p_w <= h_w + CW'(7)) begin
                        icmp_hit = 1'b1;
                        rel      = 2'(p_w - h_w);
                    end
                end else if (kind_next == cfg.time_exceeded_type) begin
                    if (p_w == h_w + CW'(8)) begin
                        off_next = 8'(hlen_next) + 8'd8 + {2'b00, in_byte_reg[3:0], 2'b00};
                    end else if (p_w > h_w + CW'(8) && p_w >= off_w + CW'(4) &&
                                 p_w <= off_w + CW'(7)) begin
                        icmp_hit = 1'b1;
                        rel      = 2'(p_w - off_w);
                    end
                end
            end
        end else begin
            hlen_next = hlen_reg;
            h_w       = CW'(hlen_reg);
        end

        // Store identifier and sequence bytes of the ICMP header
        if (icmp_hit) begin
            case (rel)
                2'd0: id_next[7:0]   = in_byte_reg;
                2'd1: id_next[15:8]  = in_byte_reg;
                2'd2: seq_next[7:0]  = in_byte_reg;
                2'd3: begin
                    seq_next[15:8] = in_byte_reg;
                    done_next      = 1'b1;
                end
                default: id_next = id_reg;
            endcase
        end
    end

    // Classify the packet from the updated fields
    always_comb begin
        is_echo = (kind_next == cfg.echo_reply_type);
        is_te   = !is_echo && (kind_next == cfg.time_exceeded_type);
        len_w   = CW'(pos_next);

        res.reply_kind    = KIND_ECHO;
        res.reached_dest  = 1'b0;
        res.source_ip     = src_next;
        res.round_trip_ms = in_now_reg - cfg.send_time;

        if (len_w < CW'(16) || len_w < CW'(hlen_next) + CW'(8)) begin
            res.status = ST_TOO_SHORT;
        end else if (!is_echo && !is_te) begin
            res.status = ST_OTHER;
        end else if (!done_next) begin
            res.status = ST_TOO_SHORT;
        end else begin
            res.reply_kind = is_te ? KIND_TIME_EXC : KIND_ECHO;
            if (id_next != cfg.process_id || seq_next != cfg.expected_seq) begin
                res.status = ST_MISMATCH;
            end else begin
                res.status       = ST_ACCEPTED;
                res.reached_dest = (src_next == cfg.dest_ip);
            end
        end
    end

    assign res_load = adv && in_last_reg;

    // Update packet state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || res_load) begin
            pos_reg  <= '0;
            hlen_reg <= '0;
            kind_reg <= '0;
            src_reg  <= '0;
            off_reg  <= '0;
            id_reg   <= '0;
            seq_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            hlen_reg <= hlen_next;
            kind_reg <= kind_next;
            src_reg  <= src_next;
            off_reg  <= off_next;
            id_reg   <= id_next;
            seq_reg  <= seq_next;
            done_reg <= done_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (pos_reg == '0 && done_reg == 1'b0))
        else $error("packet state not cleared after last byte");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("byte position beyond packet limit");

    a_len_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        hlen_reg[1:0] == 2'b00 && off_reg[1:0] == 2'b00)
        else $error("header length or inner offset not a multiple of four");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded into a full output slot");

endmodule

>>> sv/irm_out_reg.sv
// Result register of the ICMP reply matcher: holds one result word and
// packs it onto the master stream. Depends on irm_pkg.
module irm_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_load,
    input  irm_pkg::result_t               res,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);
    import irm_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    // Slot is free when empty or being drained this cycle
    assign out_free       = !out_valid_reg || m_tready;
    assign out_valid_next = res_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    // Pack the word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, res_reg.round_trip_ms, res_reg.reached_dest,
                       res_reg.source_ip, res_reg.status};
    assign m_tuser  = res_reg.reply_kind;

endmodule

>>> sv/icmp_reply_matcher_top.sv
// Top level of the ICMP reply matcher: configuration registers, byte
// parser and result register. Depends on irm_pkg and the irm_ modules.
//
// Takes a received IPv4 packet one byte per word on the slave stream, one
// word per clock, and gives one result word per packet after its last byte
// (tlast). Each byte passes an input register and is parsed from there;
// the result is registered and shows on the master stream once the last
// byte is parsed. Bytes keep flowing while a result waits, and
// only the last byte of the next packet stalls while the result register
// is full. A configuration write is taken only while no byte sits in the
// input register, and a pending write holds the slave stream for that
// cycle. Bytes at positions of MAX_PACKET_BYTES and above are dropped.
module icmp_reply_matcher_top #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] data_byte, [39:8] now_ms
    input  logic [irm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [33:2] source_ip, [34] reached_dest,
    // [66:35] round_trip_ms, [71:67] zero
    output logic [irm_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] reply_kind
    output logic                           m_tuser,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import irm_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    pipe_busy;
    logic    res_load;
    logic    out_free;

    irm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pipe_busy (pipe_busy),
        .cfg       (cfg)
    );

    irm_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata[7:0]),
        .s_last    (s_tlast),
        .s_now     (s_tdata[39:8]),
        .cfg_valid (cfg_valid),
        .cfg       (cfg),
        .out_free  (out_free),
        .pipe_busy (pipe_busy),
        .res_load  (res_load),
        .res       (res)
    );

    irm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/icmp_reply_matcher_top_test.sv
// Testbench for icmp_reply_matcher_top: packets go in one byte per word and
// each reply word is checked against a parser model held in this file.
// Depends on irm_pkg and the RTL of the block.
module icmp_reply_matcher_top_test;
    import irm_pkg::*;

    localparam int MAX_BYTES   = 1024;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 500000;

    // Ways to set the tick on the bytes of a packet
    localparam int NOW_RANDOM = 0;
    localparam int NOW_ZERO   = 1;
    localparam int NOW_ONES   = 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [7:0] data_byte, [39:8] now_ms
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [1:0] status, [33:2] source_ip, [34] reached_dest, [66:35] round_trip_ms
    logic [M_TDATA_W-1:0]  m_tdata;
    // [0] reply_kind
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PROCESS_ID;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copy and parser state of the model
    cfg_t        regs;
    int unsigned pos;
    int unsigned hdr_len;
    int unsigned inner_off;
    logic [7:0]  type_seen;
    logic [31:0] src_seen;
    logic [15:0] id_seen;
    logic [15:0] seq_seen;
    logic        ids_done;

    result_t     replies_due[$];
    result_t     want;
    logic [7:0]  frame[$];

    int gap_pct    = 0;
    int stall_pct  = 0;
    int bytes_sent = 0;
    int errors     = 0;
    int cycles     = 0;

    icmp_reply_matcher_top #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        pos       = 0;
        hdr_len   = 0;
        inner_off = 0;
        type_seen = '0;
        src_seen  = '0;
        id_seen   = '0;
        seq_seen  = '0;
        ids_done  = 1'b0;
    endfunction

    // Store bytes 4 to 7 of an ICMP header into id and sequence
    function automatic void take_icmp_field(int unsigned rel, logic [7:0] b);
        case (rel)
            4: id_seen[7:0]   = b;
            5: id_seen[15:8]  = b;
            6: seq_seen[7:0]  = b;
            7: begin
                seq_seen[15:8] = b;
                ids_done       = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(int unsigned p, logic [7:0] b);
        if (p == 0)
            hdr_len = int'(b[3:0]) << 2;
        if (p >= 12 && p <= 15)
            src_seen = src_seen | (32'(b) << (8 * (p - 12)));
        if (p == hdr_len)
            type_seen = b;
        if (p > hdr_len) begin
            if (type_seen == regs.echo_reply_type) begin
                if (p >= hdr_len + 4 && p <= hdr_len + 7)
                    take_icmp_field(p - hdr_len, b);
            end else if (type_seen == regs.time_exceeded_type) begin
                // inner IP header starts 8 bytes into the ICMP error
                if (p == hdr_len + 8)
                    inner_off = hdr_len + 8 + (int'(b[3:0]) << 2);
                else if (p > hdr_len + 8 && p >= inner_off + 4 && p <= inner_off + 7)
                    take_icmp_field(p - inner_off, b);
            end
        end
    endfunction

    // Advance the model by one accepted byte; classify on the last one
    function automatic void track_byte(logic [7:0] b, logic lst, logic [31:0] now);
        result_t r;
        logic    is_echo;
        logic    is_te;
        if (pos < MAX_BYTES) begin
            parse_byte(pos, b);
            pos++;
        end
        if (lst) begin
            is_echo         = (type_seen == regs.echo_reply_type);
            is_te           = !is_echo && (type_seen == regs.time_exceeded_type);
            r               = '0;
            r.reply_kind    = KIND_ECHO;
            r.source_ip     = src_seen;
            r.round_trip_ms = now - regs.send_time;
            if (pos < 16 || pos < hdr_len + 8)
                r.status = ST_TOO_SHORT;
            else if (!is_echo && !is_te)
                r.status = ST_OTHER;
            else if (!ids_done)
                r.status = ST_TOO_SHORT;
            else begin
                r.reply_kind = is_te ? KIND_TIME_EXC : KIND_ECHO;
                if (id_seen != regs.process_id || seq_seen != regs.expected_seq)
                    r.status = ST_MISMATCH;
                else begin
                    r.status       = ST_ACCEPTED;
                    r.reached_dest = (src_seen == regs.dest_ip);
                end
            end
            replies_due.push_back(r);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Packet building and driving
    // ------------------------------------------------------------------
    function automatic void place(int idx, logic [7:0] val);
        if (idx < frame.size())
            frame[idx] = val;
    endfunction

    // Random bytes with the header fields laid over them; a quoted frame
    // carries id and sequence in the inner ICMP header of a time exceeded
    function automatic void build_frame(int ihl, logic [7:0] icmp_type, logic quoted,
                                        int inner_ihl, logic [15:0] id_v,
                                        logic [15:0] seq_v, logic [31:0] src,
                                        int extra, int cut);
        int h;
        int id_at;
        int full;
        h     = ihl * 4;
        id_at = quoted ? h + 12 + inner_ihl * 4 : h + 4;
        full  = id_at + 4;
        if (full < 16)
            full = 16;
        full = (cut > 0) ? cut : full + extra;
        frame.delete();
        repeat (full) frame.push_back(8'($urandom));
        for (int k = 0; k < 4; k++)
            place(12 + k, src[8*k +: 8]);
        place(h, icmp_type);
        if (quoted)
            place(h + 8, {4'($urandom), 4'(inner_ihl)});
        place(id_at,     id_v[7:0]);
        place(id_at + 1, id_v[15:8]);
        place(id_at + 2, seq_v[7:0]);
        place(id_at + 3, seq_v[15:8]);
        frame[0][3:0] = 4'(ihl);
    endfunction

    // Offer one byte, idling first at random; valid is left high afterwards
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] now);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, b};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_byte(b, lst, now);
        bytes_sent++;
    endtask

    task automatic send_frame(input int now_mode);
        logic [31:0] now;
        foreach (frame[k]) begin
            now = (now_mode == NOW_ZERO) ? 32'h0 :
                  (now_mode == NOW_ONES) ? 32'hFFFF_FFFF : 32'($urandom);
            send_byte(frame[k], k == frame.size() - 1, now);
        end
    endtask

    // Drop valid and wait until every reply is in and the parser has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PROCESS_ID:    regs.process_id         = val[15:0];
            REG_EXPECTED_SEQ:  regs.expected_seq       = val[15:0];
            REG_SEND_TIME:     regs.send_time          = val;
            REG_ECHO_TYPE:     regs.echo_reply_type    = val[7:0];
            REG_TIME_EXC_TYPE: regs.time_exceeded_type = val[7:0];
            REG_DEST_IP:       regs.dest_ip            = val;
            default: ;
        endcase
    endtask

    // Write all registers, with noise in the unused upper bits
    task automatic load_settings(input cfg_t c);
        write_register(REG_PROCESS_ID,    {16'($urandom), c.process_id});
        write_register(REG_EXPECTED_SEQ,  {16'($urandom), c.expected_seq});
        write_register(REG_SEND_TIME,     c.send_time);
        write_register(REG_ECHO_TYPE,     {24'($urandom), c.echo_reply_type});
        write_register(REG_TIME_EXC_TYPE, {24'($urandom), c.time_exceeded_type});
        write_register(REG_DEST_IP,       c.dest_ip);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver and reply checks
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: reply word with none pending: expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = replies_due.pop_front();
                check_field("status",        32'(want.status),   32'(m_tdata[1:0]));
                check_field("reply_kind",    32'(want.reply_kind), 32'(m_tuser));
                check_field("source_ip",     want.source_ip,     m_tdata[33:2]);
                check_field("reached_dest",  32'(want.reached_dest), 32'(m_tdata[34]));
                check_field("round_trip_ms", want.round_trip_ms, m_tdata[66:35]);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("icmp_reply_matcher_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Echo and time exceeded under the register values from reset
    task automatic test_reset_defaults();
        build_frame(5, 8'd0, 1'b0, 5, 16'h0, 16'h0, 32'h0, 0, 0);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'd11, 1'b1, 5, 16'h0, 16'h0, 32'h0A00_0001, 0, 0);
        send_frame(NOW_ZERO);
        settle();
    endtask

    // Short packets, foreign types, id and sequence mismatches
    task automatic test_classes();
        cfg_t c;
        c.process_id         = 16'hFFFF;
        c.expected_seq       = 16'h1234;
        c.send_time          = 32'hFFFF_FFFF;
        c.echo_reply_type    = 8'd0;
        c.time_exceeded_type = 8'd11;
        c.dest_ip            = 32'hC0A8_0001;
        load_settings(c);
        build_frame(5, 8'd0, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 1);
        send_frame(NOW_ONES);
        build_frame(5, 8'd0, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 15);
        send_frame(NOW_RANDOM);
        // longest header, packet one byte short of header plus 8
        build_frame(15, 8'd0, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 67);
        send_frame(NOW_RANDOM);
        // time exceeded ending before the last inner sequence byte
        build_frame(5, 8'd11, 1'b1, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 55);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'd3, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 4, 0);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'd0, 1'b0, 5, 16'hFFFE, c.expected_seq, c.dest_ip, 0, 0);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'd0, 1'b0, 5, c.process_id, 16'h9234, c.dest_ip, 0, 0);
        send_frame(NOW_ZERO);
        build_frame(5, 8'd0, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 2, 0);
        send_frame(NOW_RANDOM);
        build_frame(6, 8'd11, 1'b1, 15, c.process_id, c.expected_seq, c.dest_ip, 3, 0);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'd11, 1'b1, 5, c.process_id, 16'h1235, 32'h0102_0304, 0, 0);
        send_frame(NOW_RANDOM);
        settle();
    endtask

    // Header lengths below 20 overlap the ICMP fields with the IP header
    task automatic test_tiny_header();
        for (int ihl = 0; ihl < 5; ihl++) begin
            build_frame(ihl, regs.echo_reply_type, 1'b0, 5, regs.process_id,
                        regs.expected_seq, regs.dest_ip, 0, 0);
            send_frame(NOW_RANDOM);
        end
        settle();
    endtask

    // Both type registers equal: the packet counts as an echo reply
    task automatic test_equal_types();
        cfg_t c;
        c                    = regs;
        c.echo_reply_type    = 8'h2A;
        c.time_exceeded_type = 8'h2A;
        load_settings(c);
        build_frame(5, 8'h2A, 1'b1, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 0);
        send_frame(NOW_RANDOM);
        build_frame(5, 8'h2A, 1'b0, 5, c.process_id, c.expected_seq, c.dest_ip, 0, 0);
        send_frame(NOW_RANDOM);
        settle();
    endtask

    // Bytes past the maximum packet size are dropped, the last still classifies
    task automatic test_overlong();
        build_frame(5, regs.echo_reply_type, 1'b0, 5, regs.process_id, regs.expected_seq,
                    regs.dest_ip, MAX_BYTES - 16, 0);
        send_frame(NOW_RANDOM);
        settle();
    endtask

    // Echo type changed while a packet is half in, before its type byte
    task automatic test_config_mid_frame();
        build_frame(5, 8'h05, 1'b0, 5, regs.process_id, regs.expected_seq,
                    regs.dest_ip, 0, 0);
        for (int k = 0; k < 10; k++)
            send_byte(frame[k], 1'b0, $urandom);
        settle();
        write_register(REG_ECHO_TYPE, 32'h05);
        cfg_valid <= 1'b0;
        for (int k = 10; k < frame.size(); k++)
            send_byte(frame[k], k == frame.size() - 1, $urandom);
        settle();
    endtask

    // Mostly well-formed replies with random content, some broken or foreign
    task automatic random_frame();
        int          pick;
        int          ihl;
        int          inner_ihl;
        int          cut;
        logic [7:0]  ty;
        logic        quoted;
        logic [15:0] id_v;
        logic [15:0] seq_v;
        logic [31:0] src;
        pick   = $urandom_range(99);
        quoted = 1'b0;
        ty     = regs.echo_reply_type;
        if (pick >= 45 && pick < 85) begin
            quoted = 1'b1;
            ty     = regs.time_exceeded_type;
        end else if (pick >= 85) begin
            quoted = 1'($urandom_range(1));
            ty     = 8'($urandom);
        end
        ihl       = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
        inner_ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
        id_v      = ($urandom_range(9) == 0) ? 16'($urandom) : regs.process_id;
        seq_v     = regs.expected_seq;
        if ($urandom_range(9) == 0)
            seq_v = seq_v ^ (16'd1 << $urandom_range(15));
        src = $urandom_range(1) ? regs.dest_ip : 32'($urandom);
        cut = ($urandom_range(6) == 0) ? $urandom_range(60, 1) : 0;
        build_frame(ihl, ty, quoted, inner_ihl, id_v, seq_v, src, $urandom_range(8), cut);
        send_frame(NOW_RANDOM);
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        for (int ph = 0; ph < 3; ph++) begin
            settle();
            c = cfg_t'({$urandom, $urandom, $urandom, $urandom});
            if (ph == 0) begin
                c.process_id      = 16'hFFFF;
                c.expected_seq    = 16'hFFFF;
                c.send_time       = 32'hFFFF_FFFF;
                c.dest_ip         = 32'hFFFF_FFFF;
                c.echo_reply_type = 8'hFF;
                c.time_exceeded_type = 8'h00;
                gap_pct   = 20;
                stall_pct = 82;
            end else if (ph == 1) begin
                c.process_id      = 16'h0;
                c.expected_seq    = 16'h0;
                c.send_time       = 32'h0;
                c.dest_ip         = 32'h0;
                c.time_exceeded_type = 8'hFF;
                gap_pct   = 82;
                stall_pct = 20;
            end else begin
                c.echo_reply_type    = 8'd0;
                c.time_exceeded_type = TIME_EXC_TYPE_RESET;
                gap_pct   = 0;
                stall_pct = 0;
            end
            load_settings(c);
            bytes_sent = 0;
            while (bytes_sent < 120)
                random_frame();
        end
    endtask

    initial begin
        regs                    = '0;
        regs.time_exceeded_type = TIME_EXC_TYPE_RESET;
        clear_parser();
        gap_pct   = 20;
        stall_pct = 82;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_classes();
        test_tiny_header();
        test_equal_types();
        test_overlong();
        test_config_mid_frame();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("icmp_reply_matcher_top regression: pass");
        else
            $display("icmp_reply_matcher_top regression: fail");
        $finish;
    end

endmodule
